@@ rtl/skm_pkg.sv @@
// Shared constants, types and a helper function of the smoothed knob to servo angle unit.
package skm_pkg;

  localparam int ADC_W   = 10;
  localparam int ANGLE_W = 8;
  localparam int BAND_W  = 4;

  localparam int WINDOW_DEFAULT = 10;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;
  localparam logic [ANGLE_W-1:0] LOW_END   = 8'd10;
  localparam logic [ANGLE_W-1:0] HIGH_END  = 8'd165;
  localparam logic [ANGLE_W-1:0] REF_RESET = 8'd90;
  localparam int                 BAND_SIZE = 30;
  localparam int                 BAND_MAX  = 8;

  // avg * 180 / 1023 is taken as avg * (180 * ceil(2^28 / 1023)) >> 28, which is
  // exact for every avg * 180 below 2^18.
  localparam int                 ANGLE_SHIFT = 28;
  localparam int                 ANGLE_MUL_W = 26;
  localparam int                 ANGLE_PROD_W = ADC_W + ANGLE_MUL_W;
  localparam logic [ANGLE_MUL_W-1:0] ANGLE_MULT = 26'd47232180;

  typedef logic [ADC_W-1:0]   level_t;
  typedef logic [ANGLE_W-1:0] angle_t;

  // Payload between the scaling stages and the flag stage.
  typedef struct packed {
    level_t level;
    angle_t angle;
  } scaled_t;

  // Which 30-degree band an angle falls in.
  function automatic logic [BAND_W-1:0] angle_band(input angle_t a);
    logic [BAND_W-1:0] b;
    b = '0;
    for (int i = 1; i <= BAND_MAX; i++) begin
      if (a >= ANGLE_W'(i * BAND_SIZE)) begin
        b = b + 1'b1;
      end
    end
    return b;
  endfunction

endpackage

@@ rtl/skm_if.sv @@
// Handshake channel interfaces for samples in and angle results out.
interface skm_sample_if
  import skm_pkg::*;
  ;
  logic   valid;
  logic   ready;
  level_t adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface skm_result_if
  import skm_pkg::*;
  ;
  logic   valid;
  logic   ready;
  level_t smoothed_level;
  angle_t servo_angle;
  angle_t mirror_angle;
  logic   indicator;

  modport source (output valid, output smoothed_level, output servo_angle,
                  output mirror_angle, output indicator, input ready);
  modport sink   (input valid, input smoothed_level, input servo_angle,
                  input mirror_angle, input indicator, output ready);
endinterface

@@ rtl/skm_ring.sv @@
// Sample ring memory and running sum: two pipeline stages.
module skm_ring
  import skm_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEFAULT,
  parameter int SUM_W  = ADC_W + $clog2(WINDOW)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  level_t           in_sample,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SUM_W-1:0] out_sum
);

  localparam int POS_W = $clog2(WINDOW);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

  level_t            mem [WINDOW];
  logic [WINDOW-1:0] filled;
  logic [POS_W-1:0]  pos;

  logic              s1_valid;
  level_t            s1_sample;
  level_t            s1_old;
  logic              s2_valid;
  logic [SUM_W-1:0]  sum;

  logic              s2_advance;
  logic              s1_advance;
  logic              accept;

  assign s2_advance = !s2_valid || out_ready;
  assign s1_advance = !s1_valid || s2_advance;
  assign in_ready   = s1_advance;
  assign accept     = in_valid && s1_advance;

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (accept) begin
      mem[pos]  <= in_sample;
      s1_sample <= in_sample;
      s1_old    <= filled[pos] ? mem[pos] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled   <= '0;
      pos      <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        filled[pos] <= 1'b1;
        pos         <= (pos == POS_LAST) ? '0 : pos + 1'b1;
      end
      if (s1_advance) begin
        s1_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      sum      <= '0;
    end else if (s2_advance) begin
      s2_valid <= s1_valid;
      if (s1_valid) begin
        sum <= sum - SUM_W'(s1_old) + SUM_W'(s1_sample);
      end
    end
  end

  assign out_valid = s2_valid;
  assign out_sum   = sum;

endmodule

@@ rtl/skm_scale.sv @@
// Average by reciprocal multiply, then mapping of the average to degrees: two stages.
module skm_scale
  import skm_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEFAULT,
  parameter int SUM_W  = ADC_W + $clog2(WINDOW)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [SUM_W-1:0] in_sum,
  output logic             out_valid,
  input  logic             out_ready,
  output scaled_t          out_data
);

  // floor(sum / WINDOW) == (sum * ceil(2^K / WINDOW)) >> K for every SUM_W-bit sum.
  localparam int                RECIP_K = SUM_W + $clog2(WINDOW);
  localparam longint unsigned   RECIP_M = ((64'd1 << RECIP_K) + WINDOW - 1) / WINDOW;
  localparam int                RECIP_W = $clog2(RECIP_M + 1);
  localparam int                PROD_W  = SUM_W + RECIP_W;

  logic                      s3_valid;
  level_t                    s3_level;
  logic                      s4_valid;
  scaled_t                   s4_data;

  logic                      s4_advance;
  logic                      s3_advance;
  logic [PROD_W-1:0]         avg_prod;
  logic [ANGLE_PROD_W-1:0]   angle_prod;
  angle_t                    angle_raw;

  assign s4_advance = !s4_valid || out_ready;
  assign s3_advance = !s3_valid || s4_advance;
  assign in_ready   = s3_advance;

  assign avg_prod   = PROD_W'(in_sum) * PROD_W'(RECIP_M);
  assign angle_prod = ANGLE_PROD_W'(s3_level) * ANGLE_PROD_W'(ANGLE_MULT);
  assign angle_raw  = angle_prod[ANGLE_SHIFT +: ANGLE_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (s3_advance) begin
        s3_valid <= in_valid;
      end
      if (s4_advance) begin
        s4_valid <= s3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_advance && in_valid) begin
      s3_level <= avg_prod[RECIP_K +: ADC_W];
    end
    if (s4_advance && s3_valid) begin
      s4_data.level <= s3_level;
      s4_data.angle <= (angle_raw > ANGLE_MAX) ? ANGLE_MAX : angle_raw;
    end
  end

  assign out_valid = s4_valid;
  assign out_data  = s4_data;

endmodule

@@ rtl/skm_flag.sv @@
// Band change detection against the reference angle, and the result register.
module skm_flag
  import skm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  scaled_t in_data,
  skm_result_if.source res
);

  angle_t reference;
  logic   res_valid;
  level_t res_level;
  angle_t res_angle;
  angle_t res_mirror;
  logic   res_flag;

  logic   advance;
  logic   flag;

  assign advance  = !res_valid || res.ready;
  assign in_ready = advance;

  assign flag = (angle_band(in_data.angle) != angle_band(reference)) ||
                (in_data.angle < LOW_END) || (in_data.angle > HIGH_END);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      reference <= REF_RESET;
    end else if (advance) begin
      res_valid <= in_valid;
      if (in_valid && flag) begin
        reference <= in_data.angle;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      res_level  <= in_data.level;
      res_angle  <= in_data.angle;
      res_mirror <= ANGLE_MAX - in_data.angle;
      res_flag   <= flag;
    end
  end

  assign res.valid          = res_valid;
  assign res.smoothed_level = res_level;
  assign res.servo_angle    = res_angle;
  assign res.mirror_angle   = res_mirror;
  assign res.indicator      = res_flag;

endmodule

@@ rtl/smoothed_knob_to_servo_angle_unit.sv @@
// Top level of the smoothed knob to servo angle unit.
//
// The knob channel carries one 10-bit converter sample per transfer. Each
// sample replaces the oldest of the last WINDOW samples, the running sum of
// those samples is divided by WINDOW, and the average is mapped to 0..180
// degrees. Each sample gives exactly one transfer on the servo channel: the
// average, the angle, the mirrored angle (180 minus the angle) and an
// indicator that is set when the angle leaves the 30-degree band of the last
// flagged angle or comes within reach of either end.
//
// A sample passes through the input, sum, average, angle and result registers
// in turn before it is offered. Throughput is one sample per cycle while the
// receiver does not stall; every stage holds its own valid bit, so a sample is
// taken while earlier results are still in flight. The rate is set by the
// running-sum stage, whose sum register feeds back on itself once per sample.
//
// Reset clears all pipeline valid bits, empties the ring (entries not yet
// written count as zero, so the average ramps up over the first WINDOW
// samples), zeroes the sum and sets the reference angle to 90 degrees. When
// the receiver stalls, the result is held and the stages behind it fill up
// one by one before knob.ready falls.
module smoothed_knob_to_servo_angle_unit
  import skm_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  skm_sample_if.sink   knob,
  skm_result_if.source servo
);

  // The sum of WINDOW ten-bit samples stays below WINDOW * 1024.
  localparam int SUM_W = ADC_W + $clog2(WINDOW);

  logic             sum_valid;
  logic             sum_ready;
  logic [SUM_W-1:0] sum;

  logic             scaled_valid;
  logic             scaled_ready;
  scaled_t          scaled;

  // Ring memory, oldest-entry pointer and running sum.
  skm_ring #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_ring (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (knob.valid),
    .in_ready  (knob.ready),
    .in_sample (knob.adc_sample),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .out_sum   (sum)
  );

  // Division by the window length and mapping to degrees.
  skm_scale #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .in_sum    (sum),
    .out_valid (scaled_valid),
    .out_ready (scaled_ready),
    .out_data  (scaled)
  );

  // Reference angle, indicator and the result register facing the receiver.
  skm_flag u_flag (
    .clk      (clk),
    .rst      (rst),
    .in_valid (scaled_valid),
    .in_ready (scaled_ready),
    .in_data  (scaled),
    .res      (servo)
  );

endmodule
